// ===== src/small_block_bitmap_allocator_assert.svh =====
// Assertion macros for the small block bitmap allocator.
// Each expects clk and rst_n in scope.
`ifndef SMALL_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define SMALL_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define SBBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sbba_pkg.sv =====
package sbba_pkg;

  localparam int MAX_WORDS   = 64;
  localparam int IDX_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int ACT_W       = $clog2(MAX_WORDS + 1);
  localparam int WORDS_W     = 7;
  localparam int COUNT_W     = 18;
  localparam int BLOCK_BYTES = 64;
  localparam int BLK_SHIFT   = 6;
  localparam int WORD_SHIFT  = 11;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_REJECT    = 3'd2,
    STAT_OUTSIDE   = 3'd3,
    STAT_NOT_ALLOC = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_NONE
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_MOD
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] request_size;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0]        region_base;
    logic [WORDS_W-1:0] small_words;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic [31:0]        block_address;
    logic [COUNT_W-1:0] used_bytes;
  } res_t;

  // lowest set bit of a word-summary vector
  function automatic logic [IDX_W-1:0] first_set(input logic [MAX_WORDS-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int k = MAX_WORDS - 1; k >= 0; k--) begin
      if (v[k]) r = IDX_W'(k);
    end
    return r;
  endfunction

  // lowest clear bit of a bitmap word
  function automatic logic [4:0] first_clear(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int k = 31; k >= 0; k--) begin
      if (!v[k]) r = 5'(k);
    end
    return r;
  endfunction

endpackage

// ===== src/small_block_bitmap_allocator.sv =====
// A word accepted in S_IDLE starts the bitmap RAM read; in S_MOD the word is modified,
// written back, and the result is loaded into the output register behind out_tvalid.
// The next word waits for S_IDLE; S_MOD is held while the output register is stalled.
// Reset (rst_n low, synchronous): bitmap reads as all zero through per-word valid bits,
// used count 64, region_base and small_words 0. No clearing pass.
`include "small_block_bitmap_allocator_assert.svh"

module small_block_bitmap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] request_size, [63:32] free_address
  input  logic        in_tuser,   // [0] req_type (0 allocate, 1 free)
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [31:0] block_address, [49:32] used_bytes, rest zero
  output logic [2:0]  out_tuser,  // [2:0] status
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sbba_pkg::*;

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_WORDS = 1'b1;

  // register file: region base and active word count
  logic [31:0]        region_base_r;
  logic [WORDS_W-1:0] small_words_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
      small_words_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_BASE:  region_base_r <= cfg_pwdata;
        REG_WORDS: small_words_r <= cfg_pwdata[WORDS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_BASE:  cfg_prdata = region_base_r;
      REG_WORDS: cfg_prdata = 32'(small_words_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // engine
  req_t req;
  cfg_t cfg;
  res_t res;
  logic res_valid, res_ready;

  assign req.req_type     = in_tuser;
  assign req.request_size = in_tdata[31:0];
  assign req.free_address = in_tdata[63:32];
  assign cfg.region_base  = region_base_r;
  assign cfg.small_words  = small_words_r;

  sbba_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register; the engine holds its result while this is full and not drained
  logic        out_valid_r;
  logic [55:0] out_data_r;
  logic [2:0]  out_user_r;

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= {6'b0, res.used_bytes, res.block_address};
      out_user_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // one request in flight: engine is busy right after an accept
  `SBBA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted while busy")
  // only a successful allocate carries an address
  `SBBA_ASSERT_NOW(a_addr_zero_on_status, out_tvalid && (out_tuser != STAT_OK), out_tdata[31:0] == 32'h0, "address on failed request")
  // used count moves in whole blocks
  `SBBA_ASSERT_NOW(a_count_aligned, out_tvalid, out_tdata[37:32] == 6'h0, "used count not block aligned")

endmodule

// ===== src/sbba_ram.sv =====
module sbba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sbba_engine.sv =====
module sbba_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            req_valid,
  output logic            req_ready,
  input  sbba_pkg::req_t  req,
  input  sbba_pkg::cfg_t  cfg,
  output logic            res_valid,
  input  logic            res_ready,
  output sbba_pkg::res_t  res
);
  import sbba_pkg::*;

  state_t state_r, state_nxt;

  op_t              op_r, op_nxt;
  status_t          stat_r, stat_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [4:0]       bit_r, bit_nxt;

  logic [MAX_WORDS-1:0] full_r, full_nxt;   // word has no free block
  logic [MAX_WORDS-1:0] valid_r, valid_nxt; // word written since reset
  logic [COUNT_W-1:0]   used_r, used_nxt;

  logic [ACT_W-1:0]     words;
  logic [MAX_WORDS-1:0] avail;
  logic [31:0]          off;
  logic                 in_region;
  logic                 accept;

  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;
  logic [31:0]      word, scan, new_word;
  logic [4:0]       j;

  // clamp word count to what the bitmap holds
  always_comb begin
    if (int'(cfg.small_words) > MAX_WORDS) words = ACT_W'(MAX_WORDS);
    else                                   words = ACT_W'(cfg.small_words);
  end

  always_comb begin
    for (int k = 0; k < MAX_WORDS; k++) begin
      avail[k] = !full_r[k] && (ACT_W'(k) < words);
    end
  end

  assign off       = req.free_address - cfg.region_base;
  assign in_region = (words != '0) && (off[31:WORD_SHIFT] < (32 - WORD_SHIFT)'(words));
  assign accept    = req_valid && req_ready;

  sbba_ram #(.WIDTH(32), .DEPTH(MAX_WORDS)) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (new_word),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request decode at accept
  always_comb begin
    op_nxt    = op_r;
    stat_nxt  = stat_r;
    idx_nxt   = idx_r;
    bit_nxt   = bit_r;
    ram_raddr = '0;
    if (accept) begin
      stat_nxt = STAT_OK;
      if (!req.req_type) begin
        idx_nxt   = first_set(avail);
        ram_raddr = idx_nxt;
        if (words == '0 || req.request_size > 32'(BLOCK_BYTES)) begin
          op_nxt   = OP_NONE;
          stat_nxt = STAT_REJECT;
        end else if (avail == '0) begin
          op_nxt   = OP_NONE;
          stat_nxt = STAT_FULL;
        end else begin
          op_nxt   = OP_ALLOC;
        end
      end else begin
        idx_nxt   = off[WORD_SHIFT +: IDX_W];
        bit_nxt   = off[WORD_SHIFT-1:BLK_SHIFT];
        ram_raddr = idx_nxt;
        if (in_region) begin
          op_nxt   = OP_FREE;
        end else begin
          op_nxt   = OP_NONE;
          stat_nxt = STAT_OUTSIDE;
        end
      end
    end
  end

  // read-modify-write of the selected bitmap word
  always_comb begin
    word     = valid_r[idx_r] ? ram_rdata : '0;
    scan     = word | ((idx_r == '0) ? 32'h1 : 32'h0);  // block 0 reserved
    j        = first_clear(scan);
    new_word = word;
    full_nxt  = full_r;
    valid_nxt = valid_r;
    used_nxt  = used_r;
    ram_we    = 1'b0;
    res.status        = stat_r;
    res.block_address = '0;
    unique case (op_r)
      OP_ALLOC: begin
        new_word = word | (32'h1 << j);
        res.block_address = cfg.region_base + 32'({idx_r, j, BLK_SHIFT'(0)});
        used_nxt = used_r + COUNT_W'(BLOCK_BYTES);
        ram_we   = 1'b1;
      end
      OP_FREE: begin
        if (word[bit_r]) begin
          new_word = word & ~(32'h1 << bit_r);
          used_nxt = used_r - COUNT_W'(BLOCK_BYTES);
          ram_we   = 1'b1;
        end else begin
          res.status = STAT_NOT_ALLOC;
        end
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
    res.used_bytes = used_nxt;
    ram_we = ram_we && res_valid && res_ready;
    if (ram_we) begin
      full_nxt[idx_r]  = &(new_word | ((idx_r == '0) ? 32'h1 : 32'h0));
      valid_nxt[idx_r] = 1'b1;
    end else begin
      used_nxt = used_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) state_nxt = S_MOD;
      end
      S_MOD: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      full_r  <= '0;
      valid_r <= '0;
      used_r  <= COUNT_W'(BLOCK_BYTES);
    end else begin
      state_r <= state_nxt;
      full_r  <= full_nxt;
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    stat_r <= stat_nxt;
    idx_r  <= idx_nxt;
    bit_r  <= bit_nxt;
  end

endmodule
